// ===== rtl/core/lcar_pkg.sv =====
// Shared types and constants for the load-cell converter reader.
package lcar_pkg;

    // Default widths of the conversion word and the result fraction
    localparam int SAMPLE_BITS_DEF   = 24;
    localparam int FRACTION_BITS_DEF = 16;

    // Fixed field widths
    localparam int GAIN_W     = 2;
    localparam int AVG_W      = 8;
    localparam int SCALE_W    = 24;
    localparam int RAW_W      = 25;
    localparam int UNITS_W    = 41;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 2;

    // Saturation limits of the result fields
    localparam logic signed [RAW_W-1:0]   RAW_MAX   = 25'sh0FF_FFFF;
    localparam logic signed [RAW_W-1:0]   RAW_MIN   = 25'sh100_0000;
    localparam logic signed [UNITS_W-1:0] UNITS_MAX = 41'sh0FF_FFFF_FFFF;
    localparam logic signed [UNITS_W-1:0] UNITS_MIN = 41'sh100_0000_0000;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_PULSES   = 2'd0,
        CFG_AVERAGE_COUNT = 2'd1,
        CFG_SCALE_DIVISOR = 2'd2,
        CFG_POWER_DOWN    = 2'd3
    } cfg_idx_t;

    // Converter line sequencing, one step per tick
    typedef enum logic [2:0] {
        PH_WAIT       = 3'd0,
        PH_BIT_HIGH   = 3'd1,
        PH_BIT_LOW    = 3'd2,
        PH_PULSE_HIGH = 3'd3,
        PH_PULSE_LOW  = 3'd4
    } phase_t;

    // Post-processing sequencer around the shared divider
    typedef enum logic [2:0] {
        CTL_IDLE   = 3'd0,
        CTL_AVG    = 3'd1,
        CTL_OFFSET = 3'd2,
        CTL_SCALE  = 3'd3,
        CTL_UNITS  = 3'd4,
        CTL_EMIT   = 3'd5
    } ctl_t;

endpackage

// ===== rtl/core/lcar_if.sv =====
// Valid/ready channel interfaces for tick words and result words.
interface lcar_in_if;
    logic valid;
    logic ready;
    logic data_level;
    logic tare_request;

    modport source (output valid, output data_level, output tare_request, input ready);
    modport sink   (input valid, input data_level, input tare_request, output ready);
endinterface

interface lcar_out_if;
    logic                                       valid;
    logic                                       ready;
    logic                                       clock_level;
    logic                                       result_valid;
    logic                                       tare_done;
    logic signed [lcar_pkg::RAW_W-1:0]          raw_value;
    logic signed [lcar_pkg::UNITS_W-1:0]        units_value;

    modport source (
        output valid, output clock_level, output result_valid, output tare_done,
        output raw_value, output units_value, input ready
    );
    modport sink (
        input valid, input clock_level, input result_valid, input tare_done,
        input raw_value, input units_value, output ready
    );
endinterface

// ===== rtl/core/lcar_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
module lcar_div #(
    parameter int NUM_W = 41,
    parameter int DEN_W = lcar_pkg::SCALE_W
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg;
    logic [CNT_W-1:0] count_reg;
    logic             done_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [NUM_W-1:0] quo_reg;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             fits;
    logic [DEN_W-1:0] rem_next;
    logic [NUM_W-1:0] quo_next;

    // Trial subtract of the divisor from the shifted partial remainder
    always_comb
    begin
        trial    = {rem_reg, quo_reg[NUM_W-1]};
        diff     = trial - {1'b0, den_reg};
        fits     = (trial >= {1'b0, den_reg});
        rem_next = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        quo_next = {quo_reg[NUM_W-2:0], fits};
    end

    // Count the steps and flag the last one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && (count_reg == CNT_W'(1));
            if (start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= CNT_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg - CNT_W'(1);
                if (count_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Load operands, then shift quotient bits in as the dividend shifts out
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            den_reg <= den;
            quo_reg <= num;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ===== rtl/core/load_cell_adc_reader_top.sv =====
// Top level of the two-wire 24-bit load-cell converter reader.
//
// Each word on sample_in is one converter tick: the sampled data line level
// and a tare request. Each accepted word yields exactly one word on
// result_out: the clock line level to drive after the tick, plus flags and
// values when an averaged conversion completes on that tick.
// A tick that completes no average is answered in the next cycle, and a new tick
// is taken every cycle while result_out keeps up. A tick that completes an
// average runs the shared restoring divider for the average and then, unless
// it takes a tare, for the scaling to Q format, one quotient bit per cycle
// on a DIV_W = max(SAMPLE_BITS + 8, 25 + FRACTION_BITS) bit dividend, and
// sample_in is not ready meanwhile.
// A finished word sits in an output register; the block accepts a tick only
// if that register is empty or is being emptied, else it holds sample_in not
// ready. Reset clears the sequencing, the running sum, the offset and a pending
// tare, clears the clock state and sets the registers to one extra pulse, an
// average of one, a scale of one and power up. Configuration writes take effect
// at once and must be made by the user while idle; it is not enforced.
module load_cell_adc_reader_top #(
    parameter int SAMPLE_BITS   = lcar_pkg::SAMPLE_BITS_DEF,
    parameter int FRACTION_BITS = lcar_pkg::FRACTION_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    lcar_in_if.sink                           sample_in,
    lcar_out_if.source                        result_out,
    input  logic                              cfg_wr_en,
    input  lcar_pkg::cfg_idx_t                cfg_index,
    input  logic [lcar_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int RAW_W   = lcar_pkg::RAW_W;
    localparam int UNITS_W = lcar_pkg::UNITS_W;
    localparam int SCALE_W = lcar_pkg::SCALE_W;
    localparam int AVG_W   = lcar_pkg::AVG_W;
    localparam int GAIN_W  = lcar_pkg::GAIN_W;
    localparam int SUM_W   = SAMPLE_BITS + 8;
    localparam int BC_W    = $clog2(SAMPLE_BITS + 1);
    localparam int UNUM_W  = RAW_W + FRACTION_BITS;
    localparam int DIV_W   = (SUM_W > UNUM_W) ? SUM_W : UNUM_W;
    localparam int CMP_W   = (SAMPLE_BITS + 1 > RAW_W) ? SAMPLE_BITS + 1 : RAW_W;
    localparam int UCMP_W  = ((DIV_W > UNITS_W) ? DIV_W : UNITS_W) + 2;

    // Configuration registers
    logic [GAIN_W-1:0]  gain_pulses_reg;
    logic [AVG_W-1:0]   average_count_reg;
    logic [SCALE_W-1:0] scale_divisor_reg;
    logic               power_down_reg;

    // Converter sequencing state
    lcar_pkg::phase_t         phase_reg, phase_next;
    logic [BC_W-1:0]          bit_counter_reg, bit_counter_next;
    logic [SAMPLE_BITS-1:0]   shift_word_reg, shift_word_next;
    logic [1:0]               pulse_counter_reg, pulse_counter_next;
    logic signed [SUM_W-1:0]  sample_sum_reg, sample_sum_next;
    logic [AVG_W-1:0]         sample_counter_reg, sample_counter_next;
    logic signed [SAMPLE_BITS-1:0] zero_offset_reg, zero_offset_next;
    logic                     tare_pending_reg, tare_pending_next;
    logic                     clock_state_reg, clock_state_next;

    // Post-processing state
    lcar_pkg::ctl_t                ctl_reg, ctl_next;
    logic                          tare_take_reg, tare_take_next;
    logic                          neg_reg, neg_next;
    logic signed [SAMPLE_BITS-1:0] avg_reg, avg_next;
    logic signed [RAW_W-1:0]       raw_reg, raw_next;
    logic signed [UNITS_W-1:0]     units_reg, units_next;
    logic                          res_valid_reg, res_valid_next;
    logic                          res_tared_reg, res_tared_next;

    // Output register
    logic                      out_valid_reg, out_valid_next;
    logic                      out_clock_reg, out_clock_next;
    logic                      out_result_reg, out_result_next;
    logic                      out_tared_reg, out_tared_next;
    logic signed [RAW_W-1:0]   out_raw_reg, out_raw_next;
    logic signed [UNITS_W-1:0] out_units_reg, out_units_next;

    // Tick evaluation
    logic                     tk_clock;
    lcar_pkg::phase_t         tk_phase;
    logic [BC_W-1:0]          tk_bits;
    logic [SAMPLE_BITS-1:0]   tk_shift;
    logic [1:0]               tk_pulses;
    logic signed [SUM_W-1:0]  tk_sum;
    logic [AVG_W-1:0]         tk_count;
    logic                     tk_finish;
    logic                     tk_neg;
    logic [SUM_W-1:0]         tk_mag;
    logic [1:0]               need_pulses;
    logic [2:0]               pulse_inc;
    logic [AVG_W-1:0]         avg_count_eff;
    logic signed [SUM_W-1:0]  sample_ext;
    logic signed [SUM_W-1:0]  sum_new;
    logic [AVG_W-1:0]         count_new;
    logic                     tare_pend_tick;

    // Arithmetic around the divider
    logic [SAMPLE_BITS:0]          avg_full;
    logic signed [SAMPLE_BITS-1:0] avg_val;
    logic signed [SAMPLE_BITS:0]   diff_val;
    logic signed [CMP_W-1:0]       diff_x;
    logic signed [RAW_W-1:0]       raw_sat;
    logic [RAW_W-1:0]              raw_mag;
    logic [SCALE_W-1:0]            scale_eff;
    logic [UCMP_W-1:0]             quo_x;
    logic [UCMP_W-1:0]             pos_lim;
    logic [UCMP_W-1:0]             neg_lim;
    logic [UCMP_W-1:0]             quo_neg;
    logic signed [UNITS_W-1:0]     units_sat;

    // Divider hookup
    logic             div_start;
    logic [DIV_W-1:0] div_num;
    logic [SCALE_W-1:0] div_den;
    logic             div_done;
    logic [DIV_W-1:0] div_quo;

    logic in_accept;
    logic out_free;

    assign out_free  = !out_valid_reg || result_out.ready;
    assign in_accept = sample_in.valid && sample_in.ready;
    assign sample_in.ready = (ctl_reg == lcar_pkg::CTL_IDLE) && out_free;

    assign result_out.valid        = out_valid_reg;
    assign result_out.clock_level  = out_clock_reg;
    assign result_out.result_valid = out_result_reg;
    assign result_out.tare_done    = out_tared_reg;
    assign result_out.raw_value    = out_raw_reg;
    assign result_out.units_value  = out_units_reg;

    // Share one divider for the average and the unit scaling
    lcar_div #(
        .NUM_W (DIV_W),
        .DEN_W (SCALE_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    // Take configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_pulses_reg   <= GAIN_W'(1);
            average_count_reg <= AVG_W'(1);
            scale_divisor_reg <= SCALE_W'(1);
            power_down_reg    <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                lcar_pkg::CFG_GAIN_PULSES:   gain_pulses_reg   <= cfg_data[GAIN_W-1:0];
                lcar_pkg::CFG_AVERAGE_COUNT: average_count_reg <= cfg_data[AVG_W-1:0];
                lcar_pkg::CFG_SCALE_DIVISOR: scale_divisor_reg <= cfg_data[SCALE_W-1:0];
                lcar_pkg::CFG_POWER_DOWN:    power_down_reg    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Evaluate one tick of the converter line sequence
    always_comb
    begin
        need_pulses    = (gain_pulses_reg == '0) ? 2'd1 : gain_pulses_reg;
        avg_count_eff  = (average_count_reg == '0) ? AVG_W'(1) : average_count_reg;
        pulse_inc      = {1'b0, pulse_counter_reg} + 3'd1;
        sample_ext     = SUM_W'($signed(shift_word_reg));
        sum_new        = sample_sum_reg + sample_ext;
        count_new      = sample_counter_reg + AVG_W'(1);
        tare_pend_tick = tare_pending_reg || sample_in.tare_request;

        tk_clock  = clock_state_reg;
        tk_phase  = phase_reg;
        tk_bits   = bit_counter_reg;
        tk_shift  = shift_word_reg;
        tk_pulses = pulse_counter_reg;
        tk_sum    = sample_sum_reg;
        tk_count  = sample_counter_reg;
        tk_finish = 1'b0;
        tk_neg    = sum_new[SUM_W-1];
        tk_mag    = sum_new[SUM_W-1] ? SUM_W'(-sum_new) : SUM_W'(sum_new);

        if (power_down_reg)
        begin
            // Hold the clock high and drop any conversion
            tk_clock  = 1'b1;
            tk_phase  = lcar_pkg::PH_WAIT;
            tk_bits   = '0;
            tk_shift  = '0;
            tk_pulses = '0;
        end
        else
        begin
            unique case (phase_reg)
                lcar_pkg::PH_WAIT:
                begin
                    if (!sample_in.data_level)
                    begin
                        tk_clock  = 1'b1;
                        tk_bits   = '0;
                        tk_shift  = '0;
                        tk_pulses = '0;
                        tk_phase  = lcar_pkg::PH_BIT_HIGH;
                    end
                    else
                    begin
                        tk_clock = 1'b0;
                    end
                end
                lcar_pkg::PH_BIT_HIGH:
                begin
                    tk_shift = {shift_word_reg[SAMPLE_BITS-2:0], sample_in.data_level};
                    tk_bits  = bit_counter_reg + BC_W'(1);
                    tk_clock = 1'b0;
                    tk_phase = lcar_pkg::PH_BIT_LOW;
                end
                lcar_pkg::PH_BIT_LOW:
                begin
                    tk_clock = 1'b1;
                    if (bit_counter_reg < BC_W'(SAMPLE_BITS))
                    begin
                        tk_phase = lcar_pkg::PH_BIT_HIGH;
                    end
                    else
                    begin
                        tk_pulses = '0;
                        tk_phase  = lcar_pkg::PH_PULSE_HIGH;
                    end
                end
                lcar_pkg::PH_PULSE_HIGH:
                begin
                    tk_clock = 1'b0;
                    if (pulse_inc >= {1'b0, need_pulses})
                    begin
                        // Conversion done: accumulate, finish the average if due
                        if (count_new >= avg_count_eff)
                        begin
                            tk_finish = 1'b1;
                            tk_sum    = '0;
                            tk_count  = '0;
                        end
                        else
                        begin
                            tk_sum   = sum_new;
                            tk_count = count_new;
                        end
                        tk_bits   = '0;
                        tk_shift  = '0;
                        tk_pulses = '0;
                        tk_phase  = lcar_pkg::PH_WAIT;
                    end
                    else
                    begin
                        tk_pulses = pulse_inc[1:0];
                        tk_phase  = lcar_pkg::PH_PULSE_LOW;
                    end
                end
                lcar_pkg::PH_PULSE_LOW:
                begin
                    tk_clock = 1'b1;
                    tk_phase = lcar_pkg::PH_PULSE_HIGH;
                end
                default:
                begin
                    tk_clock  = 1'b0;
                    tk_bits   = '0;
                    tk_shift  = '0;
                    tk_pulses = '0;
                    tk_phase  = lcar_pkg::PH_WAIT;
                end
            endcase
        end
    end

    // Sign, offset and saturation arithmetic
    always_comb
    begin
        avg_full = neg_reg ? (SAMPLE_BITS + 1)'(-div_quo) : (SAMPLE_BITS + 1)'(div_quo);
        avg_val  = avg_full[SAMPLE_BITS-1:0];

        diff_val = {avg_reg[SAMPLE_BITS-1], avg_reg}
                 - {zero_offset_reg[SAMPLE_BITS-1], zero_offset_reg};
        diff_x   = CMP_W'(diff_val);
        if (diff_x > CMP_W'(lcar_pkg::RAW_MAX))
        begin
            raw_sat = lcar_pkg::RAW_MAX;
        end
        else if (diff_x < CMP_W'(lcar_pkg::RAW_MIN))
        begin
            raw_sat = lcar_pkg::RAW_MIN;
        end
        else
        begin
            raw_sat = RAW_W'(diff_x);
        end

        raw_mag   = raw_reg[RAW_W-1] ? RAW_W'(-raw_reg) : RAW_W'(raw_reg);
        scale_eff = (scale_divisor_reg == '0) ? SCALE_W'(1) : scale_divisor_reg;

        quo_x   = UCMP_W'(div_quo);
        pos_lim = UCMP_W'({1'b0, lcar_pkg::UNITS_MAX});
        neg_lim = pos_lim + UCMP_W'(1);
        quo_neg = -quo_x;
        if (neg_reg)
        begin
            units_sat = (quo_x > neg_lim) ? lcar_pkg::UNITS_MIN : UNITS_W'(quo_neg);
        end
        else
        begin
            units_sat = (quo_x > pos_lim) ? lcar_pkg::UNITS_MAX : UNITS_W'(quo_x);
        end
    end

    // Sequence ticks, the divider passes and result words
    always_comb
    begin
        phase_next          = phase_reg;
        bit_counter_next    = bit_counter_reg;
        shift_word_next     = shift_word_reg;
        pulse_counter_next  = pulse_counter_reg;
        sample_sum_next     = sample_sum_reg;
        sample_counter_next = sample_counter_reg;
        zero_offset_next    = zero_offset_reg;
        tare_pending_next   = tare_pending_reg;
        clock_state_next    = clock_state_reg;

        ctl_next       = ctl_reg;
        tare_take_next = tare_take_reg;
        neg_next       = neg_reg;
        avg_next       = avg_reg;
        raw_next       = raw_reg;
        units_next     = units_reg;
        res_valid_next = res_valid_reg;
        res_tared_next = res_tared_reg;

        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;

        out_valid_next  = out_valid_reg && !result_out.ready;
        out_clock_next  = out_clock_reg;
        out_result_next = out_result_reg;
        out_tared_next  = out_tared_reg;
        out_raw_next    = out_raw_reg;
        out_units_next  = out_units_reg;

        unique case (ctl_reg)
            lcar_pkg::CTL_IDLE:
            begin
                if (in_accept)
                begin
                    phase_next          = tk_phase;
                    bit_counter_next    = tk_bits;
                    shift_word_next     = tk_shift;
                    pulse_counter_next  = tk_pulses;
                    sample_sum_next     = tk_sum;
                    sample_counter_next = tk_count;
                    clock_state_next    = tk_clock;
                    if (tk_finish)
                    begin
                        // Start the average division
                        div_start         = 1'b1;
                        div_num           = DIV_W'(tk_mag);
                        div_den           = SCALE_W'(count_new);
                        neg_next          = tk_neg;
                        tare_take_next    = tare_pend_tick;
                        tare_pending_next = 1'b0;
                        ctl_next          = lcar_pkg::CTL_AVG;
                    end
                    else
                    begin
                        // Answer the tick at once
                        tare_pending_next = tare_pend_tick;
                        out_valid_next    = 1'b1;
                        out_clock_next    = tk_clock;
                        out_result_next   = 1'b0;
                        out_tared_next    = 1'b0;
                        out_raw_next      = '0;
                        out_units_next    = '0;
                    end
                end
            end
            lcar_pkg::CTL_AVG:
            begin
                if (div_done)
                begin
                    avg_next = avg_val;
                    if (tare_take_reg)
                    begin
                        // Take the average as the new zero
                        zero_offset_next = avg_val;
                        raw_next         = '0;
                        units_next       = '0;
                        res_valid_next   = 1'b0;
                        res_tared_next   = 1'b1;
                        ctl_next         = lcar_pkg::CTL_EMIT;
                    end
                    else
                    begin
                        ctl_next = lcar_pkg::CTL_OFFSET;
                    end
                end
            end
            lcar_pkg::CTL_OFFSET:
            begin
                raw_next = raw_sat;
                ctl_next = lcar_pkg::CTL_SCALE;
            end
            lcar_pkg::CTL_SCALE:
            begin
                // Start the scaling division on the magnitude
                div_start = 1'b1;
                div_num   = DIV_W'(raw_mag) << FRACTION_BITS;
                div_den   = scale_eff;
                neg_next  = raw_reg[RAW_W-1];
                ctl_next  = lcar_pkg::CTL_UNITS;
            end
            lcar_pkg::CTL_UNITS:
            begin
                if (div_done)
                begin
                    units_next     = units_sat;
                    res_valid_next = 1'b1;
                    res_tared_next = 1'b0;
                    ctl_next       = lcar_pkg::CTL_EMIT;
                end
            end
            lcar_pkg::CTL_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_clock_next  = clock_state_reg;
                    out_result_next = res_valid_reg;
                    out_tared_next  = res_tared_reg;
                    out_raw_next    = raw_reg;
                    out_units_next  = units_reg;
                    ctl_next        = lcar_pkg::CTL_IDLE;
                end
            end
            default:
            begin
                ctl_next = lcar_pkg::CTL_IDLE;
            end
        endcase
    end

    // Control and converter state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= lcar_pkg::PH_WAIT;
            bit_counter_reg    <= '0;
            shift_word_reg     <= '0;
            pulse_counter_reg  <= '0;
            sample_sum_reg     <= '0;
            sample_counter_reg <= '0;
            zero_offset_reg    <= '0;
            tare_pending_reg   <= 1'b0;
            clock_state_reg    <= 1'b0;
            ctl_reg            <= lcar_pkg::CTL_IDLE;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            phase_reg          <= phase_next;
            bit_counter_reg    <= bit_counter_next;
            shift_word_reg     <= shift_word_next;
            pulse_counter_reg  <= pulse_counter_next;
            sample_sum_reg     <= sample_sum_next;
            sample_counter_reg <= sample_counter_next;
            zero_offset_reg    <= zero_offset_next;
            tare_pending_reg   <= tare_pending_next;
            clock_state_reg    <= clock_state_next;
            ctl_reg            <= ctl_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        tare_take_reg  <= tare_take_next;
        neg_reg        <= neg_next;
        avg_reg        <= avg_next;
        raw_reg        <= raw_next;
        units_reg      <= units_next;
        res_valid_reg  <= res_valid_next;
        res_tared_reg  <= res_tared_next;
        out_clock_reg  <= out_clock_next;
        out_result_reg <= out_result_next;
        out_tared_reg  <= out_tared_next;
        out_raw_reg    <= out_raw_next;
        out_units_reg  <= out_units_next;
    end

endmodule
